FILE: rtl/core/pidrs_pkg.sv
// shared constants, operation codes and control structs for the pid drive block
// used by pidrs_alu and pid_drive_with_ramp_and_sync; depends on nothing else

package pidrs_pkg;

	// fixed point and field widths
	localparam int GAIN_FRAC_BITS = 24;
	localparam int INTEGRAL_WIDTH = 48;
	localparam int MEAS_W         = 24;
	localparam int ERR_W          = MEAS_W + 2;
	localparam int DER_W          = ERR_W + 1;
	localparam int GAIN_W         = 32;
	localparam int TIME_W         = 32;
	localparam int STEP_W         = 7;
	localparam int POWER_W        = 8;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 32;

	// term magnitudes saturate at 2^CAP_LOG2
	localparam int CAP_LOG2 = 61;
	localparam int OPND_W   = CAP_LOG2 + 1;
	localparam int ADD_W    = 64;
	localparam int SUM_W    = 64;
	localparam int WIDE_W   = 65;
	localparam logic [OPND_W-1:0] TERM_CAP = {1'b1, {CAP_LOG2{1'b0}}};

	// one multiplier or dividend bit per step
	localparam int MUL_STEPS = GAIN_W;
	localparam int DIV_STEPS = OPND_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [POWER_W-2:0] POWER_MAX = '1;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P      = 4'd0,
		REG_GAIN_I      = 4'd1,
		REG_GAIN_D      = 4'd2,
		REG_SETPOINT    = 4'd3,
		REG_RAMP_EN     = 4'd4,
		REG_NORMAL_STEP = 4'd5,
		REG_HIGH_STEP   = 4'd6,
		REG_CORR_EN     = 4'd7
	} cfg_reg_t;

endpackage

FILE: rtl/core/pidrs_alu.sv
// bit-serial multiply / divide unit shared by all pid terms
// multiply is msb-first shift-add saturating at TERM_CAP, divide is restoring
// depends on pidrs_pkg

module pidrs_alu (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pidrs_pkg::alu_req_t             req,
	input  logic [pidrs_pkg::OPND_W-1:0]    opnd,
	input  logic [pidrs_pkg::GAIN_W-1:0]    scale,
	output pidrs_pkg::alu_sts_t             sts,
	output logic [pidrs_pkg::OPND_W-1:0]    result
);
	import pidrs_pkg::*;

	logic              busy_q;
	alu_op_t           op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OPND_W-1:0] acc_q;
	logic [OPND_W-1:0] opnd_q;
	logic [OPND_W-1:0] shreg_q;
	logic [GAIN_W-1:0] scale_q;

	logic              top_bit;
	logic [ADD_W-1:0]  add_a;
	logic [ADD_W-1:0]  add_b;
	logic              add_cin;
	logic [ADD_W-1:0]  add_y;
	logic              q_bit;

	assign top_bit = shreg_q[OPND_W-1];

	// one adder: acc*2 + multiplicand, or partial remainder minus divisor
	always_comb begin
		if (op_q == ALU_DIV) begin
			add_a   = ADD_W'({acc_q[GAIN_W:0], top_bit});
			add_b   = ~ADD_W'(scale_q);
			add_cin = 1'b1;
		end else begin
			add_a   = ADD_W'({acc_q, 1'b0});
			add_b   = top_bit ? ADD_W'(opnd_q) : '0;
			add_cin = 1'b0;
		end
	end

	assign add_y = add_a + add_b + ADD_W'(add_cin);
	assign q_bit = ~add_y[ADD_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= ALU_MUL;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			op_q   <= req.op;
			cnt_q  <= (req.op == ALU_DIV) ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q   <= '0;
			opnd_q  <= opnd;
			scale_q <= scale;
			shreg_q <= (req.op == ALU_DIV) ? opnd : {scale, {(OPND_W - GAIN_W){1'b0}}};
		end else if (busy_q) begin
			if (op_q == ALU_DIV) begin
				if (q_bit) begin
					acc_q <= add_y[OPND_W-1:0];
				end else begin
					acc_q <= OPND_W'({acc_q[GAIN_W-1:0], top_bit});
				end
				// quotient bits fill in from the bottom as dividend bits leave the top
				shreg_q <= {shreg_q[OPND_W-2:0], q_bit};
			end else begin
				acc_q   <= (add_y > ADD_W'(TERM_CAP)) ? TERM_CAP : add_y[OPND_W-1:0];
				shreg_q <= {shreg_q[OPND_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == '0);
	assign result   = (op_q == ALU_DIV) ? shreg_q : acc_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("alu not busy after start");

	a_mul_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && op_q == ALU_MUL) |-> (acc_q <= TERM_CAP))
		else $error("multiply accumulator above term cap");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> !busy_q)
		else $error("alu still busy after done");

endmodule

FILE: rtl/core/pid_drive_with_ramp_and_sync.sv
// PID motor drive with saturating integral, paired-side correction and slew ramp.
// Each sample request occupies the block from acceptance until its motor_power request is
// offered, so a new sample is taken only after the last one's result is loaded.
// The time goes to the shared bit-serial unit in pidrs_alu: four 32-step multiplies
// (kp*e, ki*I, that product times dt, kd*de) and one 62-step restoring divide by dt run one
// after the other, plus setup, summing, correction and ramping states.
// sample_stall is high from acceptance until the result sits in the output register; a
// waiting result does not block the next sample. cfg_ready is always high; registers are
// to be written only while the block is idle. Reset needs no clearing pass.

module pid_drive_with_ramp_and_sync (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// sample channel
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic signed [pidrs_pkg::MEAS_W-1:0]   measured,
	input  logic signed [pidrs_pkg::MEAS_W-1:0]   paired_measured,
	input  logic [pidrs_pkg::TIME_W-1:0]          now_ms,
	// power channel
	output logic                                  power_valid,
	input  logic                                  power_stall,
	output logic signed [pidrs_pkg::POWER_W-1:0]  motor_power,
	// register writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pidrs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidrs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pidrs_pkg::*;

	localparam logic [GAIN_W-1:0]        GAIN_P_RST      = GAIN_W'(13421773);
	localparam logic [GAIN_W-1:0]        GAIN_I_RST      = GAIN_W'(17);
	localparam logic [GAIN_W-1:0]        GAIN_D_RST      = GAIN_W'(503316);
	localparam logic [STEP_W-1:0]        NORMAL_STEP_RST = STEP_W'(7);
	localparam logic [STEP_W-1:0]        HIGH_STEP_RST   = STEP_W'(20);
	localparam int                       CORR_W          = MEAS_W + 2;
	localparam logic signed [CORR_W-1:0] CORR_HI         = CORR_W'(POWER_MAX);
	localparam logic signed [CORR_W-1:0] CORR_LO         = -CORR_HI;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_P_GO,
		ST_P_RUN,
		ST_I1_GO,
		ST_I1_RUN,
		ST_I2_GO,
		ST_I2_RUN,
		ST_D1_GO,
		ST_D1_RUN,
		ST_D2_GO,
		ST_D2_RUN,
		ST_SUM,
		ST_DRIVE,
		ST_CORR,
		ST_OUT
	} state_t;

	function automatic logic [POWER_W-2:0] pmag(input logic signed [POWER_W-1:0] v);
		logic [POWER_W-1:0] t;
		t = v[POWER_W-1] ? -v : v;
		return t[POWER_W-2:0];
	endfunction

	// configuration
	logic [GAIN_W-1:0]              gain_p_q;
	logic [GAIN_W-1:0]              gain_i_q;
	logic [GAIN_W-1:0]              gain_d_q;
	logic signed [MEAS_W-1:0]       setpoint_q;
	logic                           ramp_en_q;
	logic [STEP_W-1:0]              normal_step_q;
	logic [STEP_W-1:0]              high_step_q;
	logic                           corr_en_q;

	// controller state
	state_t                         state_q;
	logic signed [INTEGRAL_WIDTH-1:0] integ_q;
	logic signed [ERR_W-1:0]        prev_err_q;
	logic [TIME_W-1:0]              prev_time_q;
	logic signed [POWER_W-1:0]      last_power_q;
	logic                           power_valid_q;
	logic signed [POWER_W-1:0]      motor_power_q;

	// per-sample working registers
	logic signed [MEAS_W-1:0]       meas_q;
	logic signed [MEAS_W-1:0]       pair_q;
	logic [TIME_W-1:0]              now_q;
	logic signed [ERR_W-1:0]        e_q;
	logic signed [DER_W-1:0]        der_q;
	logic [TIME_W-1:0]              dt_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic signed [POWER_W-1:0]      drive_q;

	logic                           sample_take;
	logic                           out_free;

	logic signed [ERR_W-1:0]        err_c;
	logic signed [DER_W-1:0]        der_c;
	logic [TIME_W-1:0]              dt_raw;
	logic [TIME_W-1:0]              dt_c;
	logic signed [INTEGRAL_WIDTH:0] isum_c;
	logic signed [INTEGRAL_WIDTH-1:0] integ_c;

	logic [ERR_W-1:0]               e_mag;
	logic [DER_W-1:0]               der_mag;
	logic [INTEGRAL_WIDTH-1:0]      i_mag;
	logic [WIDE_W-1:0]              i_wide;
	logic [OPND_W-1:0]              i_opnd;

	alu_req_t                       alu_req;
	alu_sts_t                       alu_sts;
	logic [OPND_W-1:0]              alu_opnd;
	logic [GAIN_W-1:0]              alu_scale;
	logic [OPND_W-1:0]              alu_result;

	logic                           term_neg;
	logic [SUM_W-1:0]               res_w;
	logic signed [SUM_W-1:0]        term_c;

	logic [SUM_W-1:0]               sum_mag;
	logic [SUM_W-1:0]               sum_int;
	logic [POWER_W-2:0]             dmag;
	logic signed [POWER_W-1:0]      drive_c;

	logic [MEAS_W-1:0]              pm_c;
	logic [MEAS_W-1:0]              mi_c;
	logic [MEAS_W-1:0]              excess_c;
	logic signed [CORR_W-1:0]       t_c;
	logic signed [CORR_W-1:0]       t_adj;
	logic signed [CORR_W-1:0]       q_c;
	logic signed [CORR_W-1:0]       qs_c;
	logic signed [POWER_W-1:0]      corr_c;

	logic [POWER_W-2:0]             ad_c;
	logic [POWER_W-2:0]             al_c;
	logic [POWER_W-1:0]             mg_c;
	logic [POWER_W-2:0]             mg_sat;
	logic signed [POWER_W-1:0]      final_c;

	assign sample_take  = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign out_free     = !power_valid_q || !power_stall;
	assign power_valid  = power_valid_q;
	assign motor_power  = motor_power_q;
	assign cfg_ready    = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= GAIN_P_RST;
			gain_i_q      <= GAIN_I_RST;
			gain_d_q      <= GAIN_D_RST;
			setpoint_q    <= '0;
			ramp_en_q     <= 1'b1;
			normal_step_q <= NORMAL_STEP_RST;
			high_step_q   <= HIGH_STEP_RST;
			corr_en_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P:      gain_p_q      <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:      gain_i_q      <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:      gain_d_q      <= cfg_data[GAIN_W-1:0];
				REG_SETPOINT:    setpoint_q    <= cfg_data[MEAS_W-1:0];
				REG_RAMP_EN:     ramp_en_q     <= cfg_data[0];
				REG_NORMAL_STEP: normal_step_q <= cfg_data[STEP_W-1:0];
				REG_HIGH_STEP:   high_step_q   <= cfg_data[STEP_W-1:0];
				REG_CORR_EN:     corr_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// error, derivative, dt and saturating integral
	always_comb begin
		err_c  = ERR_W'(setpoint_q) - ERR_W'(meas_q);
		der_c  = DER_W'(err_c) - DER_W'(prev_err_q);
		dt_raw = now_q - prev_time_q;
		dt_c   = (dt_raw == '0) ? TIME_W'(1) : dt_raw;
		isum_c = (INTEGRAL_WIDTH + 1)'(integ_q) + (INTEGRAL_WIDTH + 1)'(err_c);
		if (isum_c[INTEGRAL_WIDTH] != isum_c[INTEGRAL_WIDTH-1]) begin
			integ_c = isum_c[INTEGRAL_WIDTH] ? {1'b1, {(INTEGRAL_WIDTH - 1){1'b0}}}
			                                 : {1'b0, {(INTEGRAL_WIDTH - 1){1'b1}}};
		end else begin
			integ_c = isum_c[INTEGRAL_WIDTH-1:0];
		end
	end

	// operand magnitudes; an integral above the cap saturates the product anyway
	always_comb begin
		e_mag   = e_q[ERR_W-1] ? -e_q : e_q;
		der_mag = der_q[DER_W-1] ? -der_q : der_q;
		i_mag   = integ_q[INTEGRAL_WIDTH-1] ? -integ_q : integ_q;
		i_wide  = WIDE_W'(i_mag);
		i_opnd  = (i_wide > WIDE_W'(TERM_CAP)) ? TERM_CAP : i_wide[OPND_W-1:0];
	end

	// requests to the shared unit
	always_comb begin
		alu_req.start = 1'b0;
		alu_req.op    = ALU_MUL;
		alu_opnd      = '0;
		alu_scale     = '0;
		case (state_q)
			ST_P_GO: begin
				alu_req.start = 1'b1;
				alu_opnd      = OPND_W'(e_mag);
				alu_scale     = gain_p_q;
			end
			ST_I1_GO: begin
				alu_req.start = 1'b1;
				alu_opnd      = i_opnd;
				alu_scale     = gain_i_q;
			end
			ST_I2_GO: begin
				alu_req.start = 1'b1;
				alu_opnd      = alu_result;
				alu_scale     = dt_q;
			end
			ST_D1_GO: begin
				alu_req.start = 1'b1;
				alu_opnd      = OPND_W'(der_mag);
				alu_scale     = gain_d_q;
			end
			ST_D2_GO: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_DIV;
				alu_opnd      = alu_result;
				alu_scale     = dt_q;
			end
			default: ;
		endcase
	end

	pidrs_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opnd   (alu_opnd),
		.scale  (alu_scale),
		.sts    (alu_sts),
		.result (alu_result)
	);

	// signed term from the last finished unit result
	always_comb begin
		case (state_q)
			ST_I1_GO: term_neg = e_q[ERR_W-1];
			ST_D1_GO: term_neg = integ_q[INTEGRAL_WIDTH-1];
			default:  term_neg = der_q[DER_W-1];
		endcase
		res_w  = SUM_W'(alu_result);
		term_c = term_neg ? -res_w : res_w;
	end

	// sum to integer drive, truncating toward zero and saturating at POWER_MAX
	always_comb begin
		sum_mag = sum_q[SUM_W-1] ? -sum_q : sum_q;
		sum_int = sum_mag >> GAIN_FRAC_BITS;
		dmag    = (sum_int > SUM_W'(POWER_MAX)) ? POWER_MAX : sum_int[POWER_W-2:0];
		drive_c = sum_q[SUM_W-1] ? -{1'b0, dmag} : {1'b0, dmag};
	end

	// paired-side correction: drive moved toward zero by half the excess, rounded toward zero
	always_comb begin
		pm_c     = meas_q[MEAS_W-1] ? -meas_q : meas_q;
		mi_c     = pair_q[MEAS_W-1] ? -pair_q : pair_q;
		excess_c = pm_c - mi_c;
		if (drive_q[POWER_W-1]) begin
			t_c = (CORR_W'(drive_q) <<< 1) + CORR_W'(excess_c);
		end else begin
			t_c = (CORR_W'(drive_q) <<< 1) - CORR_W'(excess_c);
		end
		t_adj = t_c + {{(CORR_W - 1){1'b0}}, t_c[CORR_W-1]};
		q_c   = t_adj >>> 1;
		if (q_c > CORR_HI) begin
			qs_c = CORR_HI;
		end else if (q_c < CORR_LO) begin
			qs_c = CORR_LO;
		end else begin
			qs_c = q_c;
		end
		if (corr_en_q && (pm_c > mi_c) && (drive_q != '0)) begin
			corr_c = qs_c[POWER_W-1:0];
		end else begin
			corr_c = drive_q;
		end
	end

	// slew ramp on a rising magnitude, sign of the drive kept
	always_comb begin
		ad_c   = pmag(drive_q);
		al_c   = pmag(last_power_q);
		mg_c   = (al_c < high_step_q) ? POWER_W'(high_step_q)
		                               : POWER_W'(al_c) + POWER_W'(normal_step_q);
		mg_sat = (mg_c > POWER_W'(POWER_MAX)) ? POWER_MAX : mg_c[POWER_W-2:0];
		if (ramp_en_q && (ad_c > al_c)) begin
			final_c = drive_q[POWER_W-1] ? -{1'b0, mg_sat} : {1'b0, mg_sat};
		end else begin
			final_c = drive_q;
		end
	end

	// sequencer, loop state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			integ_q       <= '0;
			prev_err_q    <= '0;
			prev_time_q   <= '0;
			last_power_q  <= '0;
			power_valid_q <= 1'b0;
			motor_power_q <= '0;
		end else begin
			// the output state reloads the register itself when it frees
			if (power_valid_q && !power_stall && (state_q != ST_OUT)) begin
				power_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_take) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					integ_q     <= integ_c;
					prev_err_q  <= err_c;
					prev_time_q <= now_q;
					state_q     <= ST_P_GO;
				end
				ST_P_GO:  state_q <= ST_P_RUN;
				ST_P_RUN: begin
					if (alu_sts.done) begin
						state_q <= ST_I1_GO;
					end
				end
				ST_I1_GO:  state_q <= ST_I1_RUN;
				ST_I1_RUN: begin
					if (alu_sts.done) begin
						state_q <= ST_I2_GO;
					end
				end
				ST_I2_GO:  state_q <= ST_I2_RUN;
				ST_I2_RUN: begin
					if (alu_sts.done) begin
						state_q <= ST_D1_GO;
					end
				end
				ST_D1_GO:  state_q <= ST_D1_RUN;
				ST_D1_RUN: begin
					if (alu_sts.done) begin
						state_q <= ST_D2_GO;
					end
				end
				ST_D2_GO:  state_q <= ST_D2_RUN;
				ST_D2_RUN: begin
					if (alu_sts.done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM:   state_q <= ST_DRIVE;
				ST_DRIVE: state_q <= ST_CORR;
				ST_CORR:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						power_valid_q <= 1'b1;
						motor_power_q <= final_c;
						last_power_q  <= final_c;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (sample_take) begin
			meas_q <= measured;
			pair_q <= paired_measured;
			now_q  <= now_ms;
		end
		case (state_q)
			ST_PREP: begin
				e_q   <= err_c;
				der_q <= der_c;
				dt_q  <= dt_c;
			end
			ST_I1_GO: sum_q   <= term_c;
			ST_D1_GO: sum_q   <= sum_q + term_c;
			ST_SUM:   sum_q   <= sum_q + term_c;
			ST_DRIVE: drive_q <= drive_c;
			ST_CORR:  drive_q <= corr_c;
			default: ;
		endcase
	end

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		sample_take |=> (state_q == ST_PREP))
		else $error("accepted sample did not start processing");

	a_alu_free: assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |-> !alu_sts.busy)
		else $error("shared unit started while busy");

	a_power_sym: assert property (@(posedge clk) disable iff (!arst_n)
		power_valid_q |-> (motor_power_q != {1'b1, {(POWER_W - 1){1'b0}}}))
		else $error("motor power outside symmetric range");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(power_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result offered outside output state");

endmodule
